// ----- src/lbmc_pkg.sv -----
// Shared constants and types for the D2Q9 TRT collision core.
package lbmc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Reset rates, given in Q2.16 and rescaled to the configured fraction width.
  localparam int RS_RESET_Q16 = 655;
  localparam int RA_RESET_Q16 = 130417;

  localparam int NPOP = 9;
  localparam int NMOV = 8;
  localparam int NE   = 4;

  localparam int EQ_STAGES  = 8;
  localparam int RLX_STAGES = 3;

  // Moving direction k (1..8) at index k-1: which velocity projection it uses
  // (ux, uy, ux+uy, ux-uy) and whether that projection is negated.
  localparam int M_SRC [NMOV] = '{0, 1, 0, 1, 2, 3, 2, 3};
  localparam bit M_NEG [NMOV] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  localparam int OPP [NPOP] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};

  typedef enum logic [0:0] {
    REG_RATE_SYM  = 1'b0,
    REG_RATE_ASYM = 1'b1
  } cfg_reg_t;

endpackage

// ----- src/lbmc_cfg.sv -----
// Relaxation rate registers.
module lbmc_cfg #(
  parameter int FRAC_BITS = lbmc_pkg::FRAC_BITS_DEF,
  localparam int W = FRAC_BITS + 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  lbmc_pkg::cfg_reg_t  cfg_index,
  input  logic [W-1:0]        cfg_data,
  output logic [W-1:0]        rs_o,
  output logic [W-1:0]        ra_o
);
  import lbmc_pkg::*;

  localparam logic [W-1:0] RS_RST = W'((64'(RS_RESET_Q16) << FRAC_BITS) >> 16);
  localparam logic [W-1:0] RA_RST = W'((64'(RA_RESET_Q16) << FRAC_BITS) >> 16);

  logic [W-1:0] rs_r;
  logic [W-1:0] ra_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= RS_RST;
      ra_r <= RA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE_SYM: begin
          rs_r <= cfg_data;
        end
        REG_RATE_ASYM: begin
          ra_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign rs_o = rs_r;
  assign ra_o = ra_r;

endmodule

// ----- src/lbmc_eq.sv -----
// Concentration and TRT equilibrium pipeline (eight stages).
module lbmc_eq #(
  parameter int FRAC_BITS = lbmc_pkg::FRAC_BITS_DEF,
  localparam int W  = FRAC_BITS + 2,
  localparam int MW = W + 2,
  localparam int PW = W + 5
) (
  input  logic                clk,
  input  logic                adv,
  input  logic signed [W-1:0] f_i [lbmc_pkg::NPOP],
  input  logic signed [W-1:0] vx_i,
  input  logic signed [W-1:0] vy_i,
  output logic signed [W-1:0] f_o [lbmc_pkg::NPOP],
  output logic signed [W-1:0] rho_o,
  output logic signed [MW-1:0] m_o [lbmc_pkg::NMOV],
  output logic signed [PW-1:0] p_o [lbmc_pkg::NE]
);
  import lbmc_pkg::*;

  localparam int DW  = W + 7;
  localparam int K3  = DW + 2;
  localparam int BW  = W + 5;
  localparam int NBW = 2 * W + 6;
  localparam int PBW = 2 * W + 5;

  localparam logic [DW:0]   M3   = (DW+1)'(((64'd1 << K3) + 64'd2) / 64'd3);
  localparam logic [DW:0]   OFF3 = (DW+1)'(64'd3 << (DW - 2));
  localparam logic [DW-1:0] QOFF = DW'(64'd1 << (DW - 2));

  localparam logic signed [NBW-1:0] TWO_S2   = NBW'(64'd1 << (2 * FRAC_BITS + 1));
  localparam logic signed [NBW:0]   SIX_S    = (NBW+1)'(64'd6 << FRAC_BITS);
  localparam logic signed [2*W+3:0] THREE_S  = (2*W+4)'(64'd3 << FRAC_BITS);
  localparam logic signed [2*W+3:0] TWELVE_S = (2*W+4)'(64'd12 << FRAC_BITS);
  localparam logic signed [PBW+1:0] THREE_SP  = (PBW+2)'(64'd3 << FRAC_BITS);
  localparam logic signed [PBW+1:0] TWELVE_SP = (PBW+2)'(64'd12 << FRAC_BITS);

  // floor(t/3): bias t to a nonnegative multiple-of-3 offset, multiply by
  // the reciprocal, then remove the bias.
  function automatic logic [DW:0] d3_pre(input logic signed [DW-1:0] t);
    return {t[DW-1], t} + OFF3;
  endfunction

  function automatic logic signed [DW-1:0] d3_post(input logic [2*DW+1:0] q);
    return q[2*DW+1:K3] - QOFF;
  endfunction

  // stage A
  logic signed [W+3:0] rsum;
  logic signed [W-1:0] rho_sat;
  logic signed [W:0]   ev [NE];

  always_comb begin
    rsum = '0;
    for (int k = 0; k < NPOP; k++) begin
      rsum = rsum + f_i[k];
    end
    if ((&rsum[W+3:W-1]) || !(|rsum[W+3:W-1])) begin
      rho_sat = rsum[W-1:0];
    end else if (rsum[W+3]) begin
      rho_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      rho_sat = {1'b0, {(W-1){1'b1}}};
    end
    ev[0] = vx_i;
    ev[1] = vy_i;
    ev[2] = vx_i + vy_i;
    ev[3] = vx_i - vy_i;
  end

  logic signed [W-1:0] f_r   [EQ_STAGES][NPOP];
  logic signed [W-1:0] rho_r [EQ_STAGES];
  logic signed [W:0]   ev_r  [NE];

  // stage B
  logic signed [2*W+1:0] sq_r [NE];
  logic signed [2*W:0]   pr_r [NE];

  // stage C
  logic signed [2*W+1:0] usq;
  logic signed [NBW-1:0] nb   [NE];
  logic signed [NBW:0]   numb [NE];
  logic signed [NBW:0]   shb  [NE];
  logic signed [DW-1:0]  tb   [NE];
  logic signed [2*W+2:0] pm   [NMOV];
  logic signed [2*W+3:0] nm   [NMOV];
  logic signed [2*W+3:0] shm  [NMOV];
  logic signed [DW-1:0]  tm   [NMOV];
  logic [DW:0]           yb_r [NE];
  logic [DW:0]           ym_r [NMOV];

  always_comb begin
    usq = sq_r[0] + sq_r[1];
    for (int j = 0; j < NE; j++) begin
      nb[j]   = TWO_S2 + 9 * sq_r[j] - 3 * usq;
      numb[j] = 2 * nb[j] + SIX_S;
      shb[j]  = numb[j] >>> (FRAC_BITS + 2);
      tb[j]   = shb[j][DW-1:0];
    end
    for (int i = 0; i < NMOV; i++) begin
      pm[i] = M_NEG[i] ? -pr_r[M_SRC[i]] : pr_r[M_SRC[i]];
      if (i >= NE) begin
        nm[i]  = 2 * pm[i] + TWELVE_S;
        shm[i] = nm[i] >>> (FRAC_BITS + 3);
      end else begin
        nm[i]  = 2 * pm[i] + THREE_S;
        shm[i] = nm[i] >>> (FRAC_BITS + 1);
      end
      tm[i] = shm[i][DW-1:0];
    end
  end

  // stage D
  logic [2*DW+1:0] qb_r [NE];
  logic [2*DW+1:0] qm_r [NMOV];

  // stage E
  logic signed [DW-1:0]  bq [NE];
  logic signed [BW-1:0]  bt [NE];
  logic signed [DW-1:0]  mq [NMOV];
  logic signed [PBW-1:0] pb_r [NE];
  logic signed [MW-1:0]  m_r [4][NMOV];

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      bq[j] = d3_post(qb_r[j]);
      bt[j] = bq[j][BW-1:0];
    end
    for (int i = 0; i < NMOV; i++) begin
      mq[i] = d3_post(qm_r[i]);
    end
  end

  // stage F
  logic signed [PBW+1:0] np  [NE];
  logic signed [PBW+1:0] shp [NE];
  logic signed [DW-1:0]  tp  [NE];
  logic [DW:0]           yp_r [NE];

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      if (j >= 2) begin
        np[j]  = 2 * pb_r[j] + TWELVE_SP;
        shp[j] = np[j] >>> (FRAC_BITS + 3);
      end else begin
        np[j]  = 2 * pb_r[j] + THREE_SP;
        shp[j] = np[j] >>> (FRAC_BITS + 1);
      end
      tp[j] = shp[j][DW-1:0];
    end
  end

  // stages G, H
  logic [2*DW+1:0]      qp_r [NE];
  logic signed [DW-1:0] pq   [NE];
  logic signed [PW-1:0] p_r  [NE];

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      pq[j] = d3_post(qp_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r[0]   <= f_i;
      rho_r[0] <= rho_sat;
      for (int s = 1; s < EQ_STAGES; s++) begin
        f_r[s]   <= f_r[s-1];
        rho_r[s] <= rho_r[s-1];
      end
      ev_r <= ev;
      for (int j = 0; j < NE; j++) begin
        sq_r[j] <= ev_r[j] * ev_r[j];
        pr_r[j] <= rho_r[0] * ev_r[j];
        yb_r[j] <= d3_pre(tb[j]);
        qb_r[j] <= yb_r[j] * M3;
        pb_r[j] <= rho_r[3] * bt[j];
        yp_r[j] <= d3_pre(tp[j]);
        qp_r[j] <= yp_r[j] * M3;
        p_r[j]  <= pq[j][PW-1:0];
      end
      for (int i = 0; i < NMOV; i++) begin
        ym_r[i]   <= d3_pre(tm[i]);
        qm_r[i]   <= ym_r[i] * M3;
        m_r[0][i] <= mq[i][MW-1:0];
      end
      for (int s = 1; s < 4; s++) begin
        m_r[s] <= m_r[s-1];
      end
    end
  end

  assign f_o   = f_r[EQ_STAGES-1];
  assign rho_o = rho_r[EQ_STAGES-1];
  assign m_o   = m_r[3];
  assign p_o   = p_r;

endmodule

// ----- src/lbmc_relax.sv -----
// Two-rate relaxation and saturation pipeline (three stages).
module lbmc_relax #(
  parameter int FRAC_BITS = lbmc_pkg::FRAC_BITS_DEF,
  localparam int W  = FRAC_BITS + 2,
  localparam int MW = W + 2,
  localparam int PW = W + 5
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [W-1:0]         rs_i,
  input  logic [W-1:0]         ra_i,
  input  logic signed [W-1:0]  f_i [lbmc_pkg::NPOP],
  input  logic signed [W-1:0]  rho_i,
  input  logic signed [MW-1:0] m_i [lbmc_pkg::NMOV],
  input  logic signed [PW-1:0] p_i [lbmc_pkg::NE],
  output logic signed [W-1:0]  pop_o [lbmc_pkg::NPOP],
  output logic signed [W-1:0]  conc_o
);
  import lbmc_pkg::*;

  localparam int AW  = W + 10;
  localparam int BBW = W + 4;
  localparam int MAW = 2 * W + 11;
  localparam int MBW = 2 * W + 5;
  localparam int NW  = 2 * W + 12;

  localparam logic signed [NW-1:0] S_N = NW'(64'd1 << FRAC_BITS);

  // stage I
  logic signed [W+7:0]  psum;
  logic signed [W+9:0]  p0;
  logic signed [AW-1:0] a  [NPOP];
  logic signed [BBW-1:0] b [NMOV];

  always_comb begin
    psum = p_i[0] + p_i[1] + p_i[2] + p_i[3];
    p0   = rho_i - (psum <<< 1);
    a[0] = (f_i[0] <<< 1) - (p0 <<< 1);
    for (int k = 1; k < NPOP; k++) begin
      a[k]   = f_i[k] + f_i[OPP[k]] - (p_i[M_SRC[k-1]] <<< 1);
      b[k-1] = f_i[k] - f_i[OPP[k]] - (m_i[k-1] <<< 1);
    end
  end

  logic signed [AW-1:0]  a_r  [NPOP];
  logic signed [BBW-1:0] b_r  [NMOV];
  logic signed [W-1:0]   f_r  [2][NPOP];
  logic signed [W-1:0]   rho_r [2];

  // stage J
  logic signed [W:0]     rsx;
  logic signed [W:0]     rax;
  logic signed [MAW-1:0] ma_r [NPOP];
  logic signed [MBW-1:0] mb_r [NMOV];

  assign rsx = $signed({1'b0, rs_i});
  assign rax = $signed({1'b0, ra_i});

  // stage K
  logic signed [NW-1:0] n    [NPOP];
  logic signed [NW-1:0] corr [NPOP];
  logic signed [NW:0]   d    [NPOP];
  logic signed [W-1:0]  ds   [NPOP];

  always_comb begin
    n[0] = ma_r[0] + S_N;
    for (int k = 1; k < NPOP; k++) begin
      n[k] = ma_r[k] + mb_r[k-1] + S_N;
    end
    for (int k = 0; k < NPOP; k++) begin
      corr[k] = n[k] >>> (FRAC_BITS + 1);
      d[k]    = f_r[1][k] - corr[k];
      if ((&d[k][NW:W-1]) || !(|d[k][NW:W-1])) begin
        ds[k] = d[k][W-1:0];
      end else if (d[k][NW]) begin
        ds[k] = {1'b1, {(W-1){1'b0}}};
      end else begin
        ds[k] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  logic signed [W-1:0] pop_r [NPOP];
  logic signed [W-1:0] conc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r      <= a;
      b_r      <= b;
      f_r[0]   <= f_i;
      f_r[1]   <= f_r[0];
      rho_r[0] <= rho_i;
      rho_r[1] <= rho_r[0];
      for (int k = 0; k < NPOP; k++) begin
        ma_r[k] <= rsx * a_r[k];
      end
      for (int i = 0; i < NMOV; i++) begin
        mb_r[i] <= rax * b_r[i];
      end
      pop_r  <= ds;
      conc_r <= rho_r[1];
    end
  end

  assign pop_o  = pop_r;
  assign conc_o = conc_r;

endmodule

// ----- src/lbm_d2q9_trt_collision_core.sv -----
// D2Q9 TRT collision core: top level with handshake and stage valid tracking.
// Fully pipelined (8 equilibrium stages, 3 relaxation stages). The whole
// pipeline holds when a result word is stalled at the output register;
// otherwise bubbles flow through and one node word is accepted per clock.
// Division by the lattice weights is done by reciprocal multiplication, each
// multiplier registered. Rates are written through cfg_we/cfg_index/cfg_data
// by the user only while idle; the block itself does not enforce this.
module lbm_d2q9_trt_collision_core #(
  parameter int FRAC_BITS = lbmc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [FRAC_BITS+1:0] in_pop_in_0,
  input  logic signed [FRAC_BITS+1:0] in_pop_in_1,
  input  logic signed [FRAC_BITS+1:0] in_pop_in_2,
  input  logic signed [FRAC_BITS+1:0] in_pop_in_3,
  input  logic signed [FRAC_BITS+1:0] in_pop_in_4,
  input  logic signed [FRAC_BITS+1:0] in_pop_in_5,
  input  logic signed [FRAC_BITS+1:0] in_pop_in_6,
  input  logic signed [FRAC_BITS+1:0] in_pop_in_7,
  input  logic signed [FRAC_BITS+1:0] in_pop_in_8,
  input  logic signed [FRAC_BITS+1:0] in_vel_x,
  input  logic signed [FRAC_BITS+1:0] in_vel_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [FRAC_BITS+1:0] out_pop_out_0,
  output logic signed [FRAC_BITS+1:0] out_pop_out_1,
  output logic signed [FRAC_BITS+1:0] out_pop_out_2,
  output logic signed [FRAC_BITS+1:0] out_pop_out_3,
  output logic signed [FRAC_BITS+1:0] out_pop_out_4,
  output logic signed [FRAC_BITS+1:0] out_pop_out_5,
  output logic signed [FRAC_BITS+1:0] out_pop_out_6,
  output logic signed [FRAC_BITS+1:0] out_pop_out_7,
  output logic signed [FRAC_BITS+1:0] out_pop_out_8,
  output logic signed [FRAC_BITS+1:0] out_concentration,
  input  logic                       cfg_we,
  input  lbmc_pkg::cfg_reg_t         cfg_index,
  input  logic [FRAC_BITS+1:0]       cfg_data
);
  import lbmc_pkg::*;

  localparam int W    = FRAC_BITS + 2;
  localparam int MW   = W + 2;
  localparam int PW   = W + 5;
  localparam int NSTG = EQ_STAGES + RLX_STAGES;

  logic [NSTG-1:0] v_r;
  logic            adv;

  assign adv      = !(v_r[NSTG-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  logic [W-1:0]         rs;
  logic [W-1:0]         ra;
  logic signed [W-1:0]  f_in  [NPOP];
  logic signed [W-1:0]  f_eq  [NPOP];
  logic signed [W-1:0]  rho_eq;
  logic signed [MW-1:0] m_eq  [NMOV];
  logic signed [PW-1:0] p_eq  [NE];
  logic signed [W-1:0]  pop   [NPOP];

  assign f_in[0] = in_pop_in_0;
  assign f_in[1] = in_pop_in_1;
  assign f_in[2] = in_pop_in_2;
  assign f_in[3] = in_pop_in_3;
  assign f_in[4] = in_pop_in_4;
  assign f_in[5] = in_pop_in_5;
  assign f_in[6] = in_pop_in_6;
  assign f_in[7] = in_pop_in_7;
  assign f_in[8] = in_pop_in_8;

  lbmc_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rs_o      (rs),
    .ra_o      (ra)
  );

  lbmc_eq #(.FRAC_BITS(FRAC_BITS)) u_eq (
    .clk   (clk),
    .adv   (adv),
    .f_i   (f_in),
    .vx_i  (in_vel_x),
    .vy_i  (in_vel_y),
    .f_o   (f_eq),
    .rho_o (rho_eq),
    .m_o   (m_eq),
    .p_o   (p_eq)
  );

  lbmc_relax #(.FRAC_BITS(FRAC_BITS)) u_relax (
    .clk    (clk),
    .adv    (adv),
    .rs_i   (rs),
    .ra_i   (ra),
    .f_i    (f_eq),
    .rho_i  (rho_eq),
    .m_i    (m_eq),
    .p_i    (p_eq),
    .pop_o  (pop),
    .conc_o (out_concentration)
  );

  assign out_pop_out_0 = pop[0];
  assign out_pop_out_1 = pop[1];
  assign out_pop_out_2 = pop[2];
  assign out_pop_out_3 = pop[3];
  assign out_pop_out_4 = pop[4];
  assign out_pop_out_5 = pop[5];
  assign out_pop_out_6 = pop[6];
  assign out_pop_out_7 = pop[7];
  assign out_pop_out_8 = pop[8];

endmodule
